// ----- src/m68kea_pkg.sv -----
// Package: request/result payload types and code constants for the effective address unit.
package m68kea_pkg;

  // Function codes of a request.
  localparam logic [1:0] FUNC_ADDR  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_BAD   = 2'd3;

  // Operand sizes.
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;
  localparam logic [1:0] SIZE_LONG = 2'd2;
  localparam logic [1:0] SIZE_BAD  = 2'd3;

  // Memory operation codes of a result.
  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_READ  = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;

  // Mode field value that selects the submode table.
  localparam logic [2:0] MODE_EXT = 3'd7;

  // General addressing modes.
  localparam logic [3:0] G_DN      = 4'd0;
  localparam logic [3:0] G_AN      = 4'd1;
  localparam logic [3:0] G_AN_IND  = 4'd2;
  localparam logic [3:0] G_POSTINC = 4'd3;
  localparam logic [3:0] G_PREDEC  = 4'd4;
  localparam logic [3:0] G_DISP    = 4'd5;
  localparam logic [3:0] G_INDEX   = 4'd6;
  localparam logic [3:0] G_ABS_W   = 4'd7;
  localparam logic [3:0] G_ABS_L   = 4'd8;
  localparam logic [3:0] G_PC_DISP = 4'd9;
  localparam logic [3:0] G_PC_IDX  = 4'd10;
  localparam logic [3:0] G_IMM     = 4'd11;

  localparam logic [2:0] REG_SP = 3'd7;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] accept_mask;
    logic [2:0]  mode;
    logic [2:0]  reg_req;
    logic [1:0]  size;
    logic [31:0] pc_base;
    logic [31:0] ext_words;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic        error;
    logic [1:0]  mem_op;
    logic [31:0] address;
    logic [31:0] reg_value;
    logic [1:0]  ext_used;
  } res_t;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sext8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [31:0] size_mask(input logic [1:0] sz);
    logic [31:0] m;
    unique case (sz)
      SIZE_BYTE: m = 32'h0000_00FF;
      SIZE_WORD: m = 32'h0000_FFFF;
      default:   m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ----- src/m68kea_req_if.sv -----
// Interface: request channel carrying one operand access request.
interface m68kea_req_if
  import m68kea_pkg::*;
();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- src/m68kea_res_if.sv -----
// Interface: result channel carrying one effective address result.
interface m68kea_res_if
  import m68kea_pkg::*;
();
  logic valid;
  logic ready;
  res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- src/m68k_effective_address_unit_top.sv -----
// Pipeline: a request is captured in the input register, then its result in the result register.
// Throughput: one request per cycle while results are accepted; the register read and address
// add are combinational, and the writeback of the eight data and eight address registers
// lands on the same edge as the result register.
// A stalled result holds the request in the input register, which then blocks new requests.
// Reset (rst, synchronous, active high) clears all sixteen registers and both valid flags.
module m68k_effective_address_unit_top
  import m68kea_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  m68kea_req_if.sink   req,
  m68kea_res_if.source res
);

  // Register file: eight data and eight address registers.
  logic [31:0] data_regs [8];
  logic [31:0] addr_regs [8];

  // Input register.
  logic in_valid;
  req_t in_q;

  // Result register.
  logic out_valid;
  res_t out_q;

  // Item in the input register moves on when the result register is free or being emptied.
  logic advance;
  assign advance   = in_valid && (!out_valid || res.ready);
  assign req.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      in_q <= req.payload;
    end
  end

  // ---------------------------------------------------------------------------
  // Decode
  // ---------------------------------------------------------------------------
  logic [3:0]  g;
  logic        err;
  logic [15:0] w1;
  logic [31:0] step;

  assign w1 = in_q.ext_words[31:16];
  assign g  = (in_q.mode != MODE_EXT) ? {1'b0, in_q.mode} : (G_ABS_W + {1'b0, in_q.reg_req});

  always_comb begin
    err = 1'b0;
    if (g > G_IMM) begin
      err = 1'b1;
    end else if (!in_q.accept_mask[g] || in_q.func == FUNC_BAD || in_q.size == SIZE_BAD) begin
      err = 1'b1;
    end else if (in_q.func == FUNC_ADDR &&
                 (g == G_DN || g == G_AN || g == G_POSTINC || g == G_PREDEC || g == G_IMM)) begin
      err = 1'b1;
    end else if (in_q.func == FUNC_WRITE && g == G_IMM) begin
      err = 1'b1;
    end
  end

  // Byte access through the stack pointer keeps it word aligned.
  always_comb begin
    unique case (in_q.size)
      SIZE_BYTE: step = (in_q.reg_req == REG_SP) ? 32'd2 : 32'd1;
      SIZE_WORD: step = 32'd2;
      default:   step = 32'd4;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Register read ports: A for the named register, B for the brief index register
  // ---------------------------------------------------------------------------
  logic [31:0] port_a;
  logic [31:0] areg;
  logic [2:0]  idx_sel;
  logic [31:0] idx_raw;
  logic [31:0] idx_val;
  logic [31:0] idx_off;

  assign areg    = addr_regs[in_q.reg_req];
  assign port_a  = (g == G_DN) ? data_regs[in_q.reg_req] : areg;
  assign idx_sel = w1[14:12];
  assign idx_raw = w1[15] ? addr_regs[idx_sel] : data_regs[idx_sel];
  assign idx_val = w1[11] ? idx_raw : sext16(idx_raw[15:0]);
  assign idx_off = idx_val + sext8(w1[7:0]);

  // ---------------------------------------------------------------------------
  // Address, value and writeback
  // ---------------------------------------------------------------------------
  res_t        res_next;
  logic        wr_en;
  logic        wr_addr_reg;
  logic [31:0] wr_value;
  logic [31:0] merged;
  logic [31:0] predec;

  assign merged = (port_a & ~size_mask(in_q.size)) | (in_q.write_data & size_mask(in_q.size));
  assign predec = areg - step;

  always_comb begin
    res_next    = '0;
    wr_en       = 1'b0;
    wr_addr_reg = 1'b1;
    wr_value    = merged;
    if (err) begin
      res_next.error = 1'b1;
    end else begin
      unique case (g)
        G_DN, G_AN: begin
          if (in_q.func == FUNC_READ) begin
            res_next.reg_value = port_a & size_mask(in_q.size);
          end else begin
            wr_en       = 1'b1;
            wr_addr_reg = (g == G_AN);
          end
        end
        G_AN_IND: res_next.address = areg;
        G_POSTINC: begin
          res_next.address = areg;
          wr_en            = 1'b1;
          wr_value         = areg + step;
        end
        G_PREDEC: begin
          res_next.address = predec;
          wr_en            = 1'b1;
          wr_value         = predec;
        end
        G_DISP: begin
          res_next.address  = areg + sext16(w1);
          res_next.ext_used = 2'd1;
        end
        G_INDEX: begin
          res_next.address  = areg + idx_off;
          res_next.ext_used = 2'd1;
        end
        G_ABS_W: begin
          res_next.address  = sext16(w1);
          res_next.ext_used = 2'd1;
        end
        G_ABS_L: begin
          res_next.address  = in_q.ext_words;
          res_next.ext_used = 2'd2;
        end
        G_PC_DISP: begin
          res_next.address  = in_q.pc_base + sext16(w1);
          res_next.ext_used = 2'd1;
        end
        G_PC_IDX: begin
          res_next.address  = in_q.pc_base + idx_off;
          res_next.ext_used = 2'd1;
        end
        default: begin
          // Immediate: byte takes the low byte of the first word, word the first word, long both words.
          unique case (in_q.size)
            SIZE_BYTE: begin
              res_next.reg_value = {24'd0, w1[7:0]};
              res_next.ext_used  = 2'd1;
            end
            SIZE_WORD: begin
              res_next.reg_value = {16'd0, w1};
              res_next.ext_used  = 2'd1;
            end
            default: begin
              res_next.reg_value = in_q.ext_words;
              res_next.ext_used  = 2'd2;
            end
          endcase
        end
      endcase
      if (g >= G_AN_IND && g <= G_PC_IDX && in_q.func != FUNC_ADDR) begin
        res_next.mem_op = in_q.func;
      end
    end
  end

  // Register file write lands on the same edge as the result, so the next
  // request in the input register already sees it.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        data_regs[i] <= '0;
        addr_regs[i] <= '0;
      end
    end else if (advance && wr_en) begin
      if (wr_addr_reg) begin
        addr_regs[in_q.reg_req] <= wr_value;
      end else begin
        data_regs[in_q.reg_req] <= wr_value;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_q <= res_next;
    end
  end

  assign res.valid   = out_valid;
  assign res.payload = out_q;

endmodule
